>>> design/cbhd_pkg.sv
// Package for the CBOR head stream decoder.
// Holds the transaction structs, the parser phase encoding and the kind/error codes.
// No dependencies.
package cbhd_pkg;

  // Item kinds on the result channel
  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_ARRAY    = 2'd1;
  localparam logic [1:0] KIND_BYTES    = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MAJOR    = 2'd1;
  localparam logic [1:0] ERR_RESERVED = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  // CBOR major types handled here
  localparam logic [2:0] MAJOR_UINT  = 3'd0;
  localparam logic [2:0] MAJOR_BYTES = 3'd2;
  localparam logic [2:0] MAJOR_ARRAY = 3'd4;

  // Additional info boundaries
  localparam logic [4:0] ADD_EXT_FIRST  = 5'd24;
  localparam logic [4:0] ADD_RESV_FIRST = 5'd28;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HEAD    = 4'b0001,
    PH_EXT     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_SKIP    = 4'b1000
  } cbhd_phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } cbhd_in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [63:0] head_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  error_code;
  } cbhd_out_t;

endpackage

>>> design/cbor_head_stream_decoder_top.sv
// Top level of the CBOR head stream decoder.
// Input register, parser core (cbhd_parser) and result register.
// Depends on cbhd_pkg and cbhd_parser.

// Accepts one CBOR byte per cycle while in_stall is low and reports unsigned,
// array and byte string heads with their 64-bit value, byte string payload
// bytes (last one marked), and error codes; after an error, bytes up to the
// buffer end give nothing. Throughput is one byte per clock while in_stall is
// low; a result passes the input register, then the result register.
// Payload bytes are sent before truncation is known, so drop them when a
// truncation error follows.
// A byte that yields a result waits in the input register while the result
// register is stalled; bytes that yield no result pass through regardless.
module cbor_head_stream_decoder_top import cbhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cbhd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cbhd_out_t out_data
);

  logic      in_valid_r;
  cbhd_in_t  in_item_r;
  logic      out_valid_r;
  cbhd_out_t out_data_r;

  logic      has_result;
  cbhd_out_t result;
  logic      out_free;
  logic      advance;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && (!has_result || out_free);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cbhd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (in_item_r),
    .has_result (has_result),
    .result     (result)
  );

  // Input register: load a new transaction whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && has_result) begin
      out_data_r <= result;
    end
  end

endmodule

>>> design/cbhd_parser.sv
// Parser core of the CBOR head stream decoder: phase, head and payload counters.
// Computes the result of one byte combinationally and updates state on fire.
// Depends on cbhd_pkg.
module cbhd_parser import cbhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  cbhd_in_t  item,
  output logic      has_result,
  output cbhd_out_t result
);

  cbhd_phase_t phase_r, phase_nxt;
  logic [3:0]  hbl_r, hbl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [1:0]  pk_r, pk_nxt;

  logic [7:0]  b;
  logic        bend;
  logic [2:0]  major;
  logic [4:0]  add;
  logic [63:0] acc_shift;
  logic        major_ok;
  logic [1:0]  major_kind;
  logic        do_fin;
  logic [1:0]  fin_kind;
  logic [63:0] fin_val;
  logic        do_err;
  logic [1:0]  err;

  assign b         = item.data_byte;
  assign bend      = item.buffer_end;
  assign major     = b[7:5];
  assign add       = b[4:0];
  assign acc_shift = {acc_r[55:0], b};

  // Map the major type to an item kind
  always_comb begin
    major_ok   = 1'b1;
    major_kind = KIND_UNSIGNED;
    case (major)
      MAJOR_UINT:  major_kind = KIND_UNSIGNED;
      MAJOR_BYTES: major_kind = KIND_BYTES;
      MAJOR_ARRAY: major_kind = KIND_ARRAY;
      default:     major_ok   = 1'b0;
    endcase
  end

  // Next state and result for the current byte
  always_comb begin
    phase_nxt  = phase_r;
    hbl_nxt    = hbl_r;
    acc_nxt    = acc_r;
    pl_nxt     = pl_r;
    pk_nxt     = pk_r;
    result     = '0;
    has_result = 1'b0;
    do_fin     = 1'b0;
    fin_kind   = pk_r;
    fin_val    = acc_shift;
    do_err     = 1'b0;
    err        = ERR_NONE;

    case (phase_r)
      PH_HEAD: begin
        if (!major_ok) begin
          do_err = 1'b1;
          err    = ERR_MAJOR;
        end else if (add >= ADD_RESV_FIRST) begin
          do_err = 1'b1;
          err    = ERR_RESERVED;
        end else if (add < ADD_EXT_FIRST) begin
          do_fin   = 1'b1;
          fin_kind = major_kind;
          fin_val  = {59'd0, add};
        end else if (bend) begin
          do_err = 1'b1;
          err    = ERR_TRUNC;
        end else begin
          pk_nxt    = major_kind;
          acc_nxt   = '0;
          hbl_nxt   = 4'(4'd1 << add[1:0]);
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        acc_nxt = acc_shift;
        if (hbl_r <= 4'd1) begin
          hbl_nxt = '0;
          do_fin  = 1'b1;
        end else begin
          hbl_nxt = hbl_r - 4'd1;
          if (bend) begin
            do_err = 1'b1;
            err    = ERR_TRUNC;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pl_r <= 64'd1) begin
          pl_nxt              = '0;
          phase_nxt           = PH_HEAD;
          has_result          = 1'b1;
          result.item_kind    = KIND_PAYLOAD;
          result.payload_byte = b;
          result.payload_last = 1'b1;
        end else begin
          pl_nxt = pl_r - 64'd1;
          if (bend) begin
            pl_nxt = '0;
            do_err = 1'b1;
            err    = ERR_TRUNC;
          end else begin
            has_result          = 1'b1;
            result.item_kind    = KIND_PAYLOAD;
            result.payload_byte = b;
          end
        end
      end
      PH_SKIP: begin
        if (bend) phase_nxt = PH_HEAD;
      end
      default: begin
        phase_nxt = PH_HEAD;
      end
    endcase

    // Complete a head; a nonempty byte string opens its payload, or is a truncation error at the buffer end
    if (do_fin) begin
      if (fin_kind == KIND_BYTES && fin_val != 64'd0) begin
        if (bend) begin
          do_err = 1'b1;
          err    = ERR_TRUNC;
        end else begin
          pl_nxt            = fin_val;
          phase_nxt         = PH_PAYLOAD;
          has_result        = 1'b1;
          result.item_kind  = fin_kind;
          result.head_value = fin_val;
        end
      end else begin
        phase_nxt           = PH_HEAD;
        has_result          = 1'b1;
        result.item_kind    = fin_kind;
        result.head_value   = fin_val;
        result.payload_last = (fin_kind == KIND_BYTES);
      end
    end

    // Report an error and skip to the buffer end
    if (do_err) begin
      phase_nxt         = bend ? PH_HEAD : PH_SKIP;
      hbl_nxt           = '0;
      has_result        = 1'b1;
      result            = '0;
      result.error_code = err;
    end
  end

  // Advance state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      hbl_r   <= '0;
      acc_r   <= '0;
      pl_r    <= '0;
      pk_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hbl_r   <= hbl_nxt;
      acc_r   <= acc_nxt;
      pl_r    <= pl_nxt;
      pk_r    <= pk_nxt;
    end
  end

endmodule

>>> bench/cbor_head_stream_decoder_top_test.sv
// Self-checking bench for cbor_head_stream_decoder_top: drives CBOR buffers byte by byte,
// tracks the expected heads, payload bytes and error codes, and checks every result.
// Depends on cbhd_pkg and the decoder RTL.
module cbor_head_stream_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cbhd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int TOTAL_BYTES  = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // Expected-result tracker: follows the head parser and queues what each byte yields
  class cbor_result_scoreboard;
    cbhd_phase_t parse_phase;
    logic [3:0]  head_left;
    logic [63:0] value_acc;
    logic [63:0] payload_left;
    logic [1:0]  head_kind;
    cbhd_out_t   pending_results[$];
    int unsigned failures;

    function new();
      parse_phase  = PH_HEAD;
      head_left    = '0;
      value_acc    = '0;
      payload_left = '0;
      head_kind    = KIND_UNSIGNED;
      failures     = 0;
    endfunction

    function void push_result(logic [1:0] kind, logic [63:0] value, logic [7:0] pbyte,
                              logic last, logic [1:0] err);
      cbhd_out_t r;
      r.item_kind    = kind;
      r.head_value   = value;
      r.payload_byte = pbyte;
      r.payload_last = last;
      r.error_code   = err;
      pending_results.push_back(r);
    endfunction

    // Report an error; skip to buffer end unless this byte is the end
    function void push_error(logic [1:0] err, logic at_end);
      if (at_end) parse_phase = PH_HEAD;
      else parse_phase = PH_SKIP;
      head_left = '0;
      push_result(KIND_UNSIGNED, '0, '0, 1'b0, err);
    endfunction

    // Complete head: a nonempty byte string opens its payload
    function void finish_head(logic [1:0] kind, logic [63:0] value, logic at_end);
      if (kind == KIND_BYTES && value != 0) begin
        if (at_end) begin
          push_error(ERR_TRUNC, 1'b1);
        end else begin
          payload_left = value;
          parse_phase  = PH_PAYLOAD;
          push_result(kind, value, '0, 1'b0, ERR_NONE);
        end
      end else begin
        parse_phase = PH_HEAD;
        push_result(kind, value, '0, kind == KIND_BYTES, ERR_NONE);
      end
    endfunction

    function void note_byte(cbhd_in_t t);
      logic [2:0] major;
      logic [4:0] addl;
      logic [1:0] kind;
      major = t.data_byte[7:5];
      addl  = t.data_byte[4:0];
      kind  = KIND_UNSIGNED;
      case (parse_phase)
        PH_HEAD: begin
          if (major == MAJOR_UINT) kind = KIND_UNSIGNED;
          else if (major == MAJOR_BYTES) kind = KIND_BYTES;
          else if (major == MAJOR_ARRAY) kind = KIND_ARRAY;
          if (major != MAJOR_UINT && major != MAJOR_BYTES && major != MAJOR_ARRAY) begin
            push_error(ERR_MAJOR, t.buffer_end);
          end else if (addl >= ADD_RESV_FIRST) begin
            push_error(ERR_RESERVED, t.buffer_end);
          end else if (addl < ADD_EXT_FIRST) begin
            finish_head(kind, addl, t.buffer_end);
          end else if (t.buffer_end) begin
            push_error(ERR_TRUNC, 1'b1);
          end else begin
            head_kind   = kind;
            value_acc   = '0;
            head_left   = 4'd1 << (addl - ADD_EXT_FIRST);
            parse_phase = PH_EXT;
          end
        end
        PH_EXT: begin
          // Shift in big-endian value bytes
          value_acc = {value_acc[55:0], t.data_byte};
          if (head_left <= 1) begin
            head_left = '0;
            finish_head(head_kind, value_acc, t.buffer_end);
          end else begin
            head_left = head_left - 4'd1;
            if (t.buffer_end) push_error(ERR_TRUNC, 1'b1);
          end
        end
        PH_PAYLOAD: begin
          if (payload_left <= 1) begin
            payload_left = '0;
            parse_phase  = PH_HEAD;
            push_result(KIND_PAYLOAD, '0, t.data_byte, 1'b1, ERR_NONE);
          end else begin
            payload_left = payload_left - 64'd1;
            if (t.buffer_end) begin
              payload_left = '0;
              push_error(ERR_TRUNC, 1'b1);
            end else begin
              push_result(KIND_PAYLOAD, '0, t.data_byte, 1'b0, ERR_NONE);
            end
          end
        end
        default: begin
          if (t.buffer_end) parse_phase = PH_HEAD;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(cbhd_out_t got);
      cbhd_out_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("item_kind", want.item_kind, got.item_kind);
      compare_field("head_value", want.head_value, got.head_value);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_last", want.payload_last, got.payload_last);
      compare_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cbhd_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  cbhd_out_t out_data;

  cbor_result_scoreboard board;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_request;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  logic [7:0]  frame_bytes[$];
  int          item_starts[$];

  cbor_head_stream_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cbor_head_stream_decoder_top verification failed");
      $finish;
    end
  end

  // Observe accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
        @(negedge clk);
      end
    end
  end

  // Offer one byte, hold it until accepted
  task automatic send_byte(logic [7:0] value, logic last);
    cbhd_in_t t;
    t.data_byte  = value;
    t.buffer_end = last;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic logic [63:0] pick_value(int width);
    logic [63:0] v;
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (width == 0) return 64'($urandom_range(23, 0));
    if (sel == 0) v = '0;
    else if (sel == 1) v = '1;
    else v = {$urandom, $urandom};
    if (width < 8) v = v & ((64'd1 << (8 * width)) - 64'd1);
    return v;
  endfunction

  // Append one head; width 0 means immediate value
  function automatic void add_head(logic [2:0] major, int width, logic [63:0] value);
    logic [4:0] addl;
    case (width)
      1:       addl = ADD_EXT_FIRST;
      2:       addl = ADD_EXT_FIRST + 5'd1;
      4:       addl = ADD_EXT_FIRST + 5'd2;
      8:       addl = ADD_EXT_FIRST + 5'd3;
      default: addl = value[4:0];
    endcase
    frame_bytes.push_back({major, addl});
    for (int i = width - 1; i >= 0; i--) frame_bytes.push_back(value[8 * i +: 8]);
  endfunction

  function automatic int pick_width();
    int unsigned sel;
    sel = $urandom_range(4, 0);
    if (sel == 0) return 0;
    return 1 << (sel - 1);
  endfunction

  // Append one well-formed item: integer, array head, or byte string with payload
  function automatic void add_item();
    int unsigned sel;
    int          width;
    logic [63:0] len;
    sel = $urandom_range(3, 0);
    item_starts.push_back(frame_bytes.size());
    if (sel == 0) begin
      width = pick_width();
      add_head(MAJOR_UINT, width, pick_value(width));
    end else if (sel == 1) begin
      width = pick_width();
      add_head(MAJOR_ARRAY, width, pick_value(width));
    end else begin
      // keep payloads short; long-form lengths stay small
      sel = $urandom_range(9, 0);
      if (sel < 7) begin
        width = 0;
        len = 64'($urandom_range(23, 0));
      end else if (sel < 9) begin
        width = 1;
        len = 64'($urandom_range(30, 0));
      end else begin
        width = 2 << $urandom_range(2, 0);
        if (width > 8) width = 8;
        len = 64'($urandom_range(20, 0));
      end
      add_head(MAJOR_BYTES, width, len);
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    end
  endfunction

  // Build a buffer: mostly well-formed items, sometimes cut, corrupted or noise
  function automatic void build_frame();
    int unsigned count;
    int unsigned keep;
    int          pos;
    logic [2:0]  major;
    frame_bytes.delete();
    item_starts.delete();
    count = $urandom_range(5, 1);
    for (int i = 0; i < count; i++) add_item();
    if ($urandom_range(99, 0) < 18) begin
      pos = item_starts[$urandom_range(item_starts.size() - 1, 0)];
      case ($urandom_range(3, 0))
        0: begin
          if (frame_bytes.size() > 1) begin
            keep = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
          end
        end
        1: begin
          do major = 3'($urandom_range(7, 0));
          while (major == MAJOR_UINT || major == MAJOR_BYTES || major == MAJOR_ARRAY);
          frame_bytes.insert(pos, {major, 5'($urandom)});
        end
        2: begin
          case ($urandom_range(2, 0))
            0:       major = MAJOR_UINT;
            1:       major = MAJOR_BYTES;
            default: major = MAJOR_ARRAY;
          endcase
          frame_bytes.insert(pos, {major, 5'($urandom_range(31, ADD_RESV_FIRST))});
        end
        default: begin
          frame_bytes.delete();
          count = $urandom_range(8, 1);
          for (int i = 0; i < count; i++) frame_bytes.push_back(8'($urandom));
        end
      endcase
    end
  endfunction

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Directed bytes as {buffer_end, data_byte}
  logic [8:0] directed_bytes[] = '{
    // zero and the largest 8-byte unsigned
    {1'b0, 8'h00},
    {1'b0, 8'h1B}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    // array with 1-byte count, empty string, 2-byte string
    {1'b0, 8'h98}, {1'b0, 8'h05},
    {1'b0, 8'h40},
    {1'b0, 8'h42}, {1'b0, 8'hAA}, {1'b1, 8'h55},
    // bad major and bad additional info together, then skip to buffer end
    {1'b0, 8'hFC}, {1'b0, 8'h01}, {1'b1, 8'h02},
    // reserved additional info at buffer end
    {1'b1, 8'h1C},
    // end inside a 2-byte length
    {1'b0, 8'h59}, {1'b1, 8'h01},
    // end right after a nonempty string head
    {1'b1, 8'h41},
    // end inside a payload
    {1'b0, 8'h43}, {1'b0, 8'h11}, {1'b1, 8'h22}
  };

  initial begin
    board          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    src_idle_pct   = 7;
    sink_stall_pct = 76;
    hold_request   = 1'b0;
    bytes_sent     = 0;
    cycle_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    // Three idling profiles; the last one starts with a long receiver hold-off
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct   = 7;
          sink_stall_pct = 76;
        end
        1: begin
          src_idle_pct   = 76;
          sink_stall_pct = 7;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_request   = 1'b1;
        end
      endcase
      while (bytes_sent < directed_bytes.size() + (p + 1) * TOTAL_BYTES / 3) begin
        build_frame();
        send_frame();
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("cbor_head_stream_decoder_top verification clean");
    end else begin
      $display("cbor_head_stream_decoder_top verification failed");
    end
    $finish;
  end
endmodule

>>> cbor_head_stream_decoder_top.f
design/cbhd_pkg.sv
design/cbhd_parser.sv
design/cbor_head_stream_decoder_top.sv
bench/cbor_head_stream_decoder_top_test.sv
